FILE: sv/skp_pkg.sv
`default_nettype none
package skp_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;

    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 16;
    localparam int X_W      = 10;
    localparam int GAP_W    = 8;
    localparam int STATUS_W = 2;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [STATUS_W-1:0] ST_PLACED     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_WIDE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HEIGHT_SAT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RSVD       = 2'd3;

    localparam logic REG_SHEET_WIDTH = 1'b0;
    localparam logic REG_COLUMN_GAP  = 1'b1;

    localparam logic [WIDTH_W-1:0] SHEET_WIDTH_RST = 11'd1024;
    localparam logic [GAP_W-1:0]   COLUMN_GAP_RST  = 8'd2;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [WIDTH_W-1:0] sheet_width;
        logic [GAP_W-1:0]   column_gap;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_CALC  = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage
`default_nettype wire

FILE: sv/skp_ifs.sv
`default_nettype none
interface skp_piece_if import skp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                new_sheet;
    logic [WIDTH_W-1:0]  piece_width;
    logic [HEIGHT_W-1:0] piece_height;

    modport source (output valid, new_sheet, piece_width, piece_height, input ready);
    modport sink   (input valid, new_sheet, piece_width, piece_height, output ready);
endinterface

interface skp_place_if import skp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [X_W-1:0]      place_x;
    logic [HEIGHT_W-1:0] place_y;
    logic [STATUS_W-1:0] status;

    modport source (output valid, place_x, place_y, status, input ready);
    modport sink   (input valid, place_x, place_y, status, output ready);
endinterface
`default_nettype wire

FILE: sv/skp_cell.sv
`default_nettype none
module skp_cell import skp_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_clear,
    input  wire logic                i_shift,
    input  wire logic [HEIGHT_W-1:0] i_d,
    output logic      [HEIGHT_W-1:0] o_q
);

    logic [HEIGHT_W-1:0] r_height;
    logic [HEIGHT_W-1:0] n_height;

    always_comb begin
        priority if (i_clear) begin
            n_height = '0;
        end else if (i_shift) begin
            n_height = i_d;
        end else begin
            n_height = r_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= '0;
        end else begin
            r_height <= n_height;
        end
    end

    assign o_q = r_height;

endmodule
`default_nettype wire

FILE: sv/skp_cfg.sv
`default_nettype none
module skp_cfg import skp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    logic wr_en;
    logic reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sheet_width <= SHEET_WIDTH_RST;
            r_cfg.column_gap  <= COLUMN_GAP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SHEET_WIDTH: r_cfg.sheet_width <= pwdata[WIDTH_W-1:0];
                REG_COLUMN_GAP:  r_cfg.column_gap  <= pwdata[GAP_W-1:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SHEET_WIDTH: prdata = APB_DW'(r_cfg.sheet_width);
            REG_COLUMN_GAP:  prdata = APB_DW'(r_cfg.column_gap);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

FILE: sv/skyline_atlas_placer.sv
// Skyline packer for texture sheets.
// Input channel i_piece carries one word per piece: new_sheet, piece_width,
// piece_height. Output channel o_place returns one word per piece: place_x,
// place_y and status (placed, too wide, height saturated).
// Sheet width and column gap are set over the APB port (0x0 and 0x4); the user
// must write them only while the block is idle, which the block does not enforce.
// The skyline lives in a ring of MAX_COLUMNS cells that rotates by one column
// per cycle while a piece is in S_SCAN or S_WRITE. A piece takes one full turn
// (S_SCAN) to find its top row, a step in S_CALC to set its top and the next
// cursor, and one full turn (S_WRITE) to raise its columns, then waits in S_DONE.
// A piece that is too wide skips both turns and goes straight to S_DONE.
// One piece is worked on at a time; i_piece.ready is high only between pieces.
// A new piece is accepted only once the last one has left S_DONE.
// The result sits in an output register, and the next piece is accepted while
// it waits. If o_place stalls, a finished result waits until the register is
// free.
// Reset clears every column, the cursor, the registers to their defaults
// (width 1024, gap 2) and the output valid.
`default_nettype none
module skyline_atlas_placer import skp_pkg::*; #(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    skp_piece_if.sink              i_piece,
    skp_place_if.source            o_place,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int CW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CMPW = ((CW > WIDTH_W + 1) ? CW : WIDTH_W + 1) + 1;
    localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLUMNS - 1);

    t_cfg cfg;

    skp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    t_state r_state;
    logic [CW-1:0]        r_col;
    logic [WIDTH_W-1:0]   r_cursor;
    logic [WIDTH_W-1:0]   r_x;
    logic [WIDTH_W:0]     r_end;
    logic [HEIGHT_W-1:0]  r_h;
    logic [HEIGHT_W-1:0]  r_y;
    logic [HEIGHT_W-1:0]  r_top;
    logic [STATUS_W-1:0]  r_status;
    logic                 r_ov;
    logic [X_W-1:0]       r_out_x;
    logic [HEIGHT_W-1:0]  r_out_y;
    logic [STATUS_W-1:0]  r_out_status;

    logic [WIDTH_W-1:0]   eff_w;
    logic                 accept;
    logic [WIDTH_W-1:0]   cur;
    logic                 too_wide;
    logic                 wrap;
    logic [WIDTH_W-1:0]   x_start;
    logic                 in_range;
    logic                 col_last;
    logic                 can_load;
    logic [HEIGHT_W:0]    top_sum;
    logic [WIDTH_W+1:0]   next_cur;
    logic                 ring_clear;
    logic                 ring_shift;
    logic [HEIGHT_W-1:0]  head;
    logic [HEIGHT_W-1:0]  wrap_d;
    logic [HEIGHT_W-1:0]  col_q [MAX_COLUMNS];

    assign eff_w = (int'(cfg.sheet_width) > MAX_COLUMNS) ? WIDTH_W'(MAX_COLUMNS)
                                                         : cfg.sheet_width;

    assign i_piece.ready = (r_state == S_IDLE);
    assign accept        = i_piece.valid && i_piece.ready;

    assign cur      = i_piece.new_sheet ? '0 : r_cursor;
    assign too_wide = i_piece.piece_width > eff_w;
    assign wrap     = (cur >= eff_w) ||
                      (({1'b0, cur} + {1'b0, i_piece.piece_width}) > {1'b0, eff_w});
    assign x_start  = wrap ? '0 : cur;

    assign in_range = (CMPW'(r_col) >= CMPW'(r_x)) && (CMPW'(r_col) < CMPW'(r_end));
    assign col_last = (r_col == COL_LAST);
    assign can_load = !r_ov || o_place.ready;
    assign top_sum  = {1'b0, r_y} + {1'b0, r_h};
    assign next_cur = {1'b0, r_end} + (WIDTH_W + 2)'(cfg.column_gap);

    // ring: column r_col sits in cell 0 during each turn
    assign ring_clear = accept && i_piece.new_sheet;
    assign ring_shift = (r_state == S_SCAN) || (r_state == S_WRITE);
    assign head       = col_q[0];
    assign wrap_d     = ((r_state == S_WRITE) && in_range) ? r_top : head;

    for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_ring
        logic [HEIGHT_W-1:0] d;
        if (g == MAX_COLUMNS - 1) begin : g_tail
            assign d = wrap_d;
        end else begin : g_body
            assign d = col_q[g+1];
        end
        skp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (ring_clear),
            .i_shift (ring_shift),
            .i_d     (d),
            .o_q     (col_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_col    <= '0;
            r_cursor <= '0;
            r_ov     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cursor <= cur;
                        r_col    <= '0;
                        r_state  <= too_wide ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_col <= col_last ? '0 : r_col + 1'b1;
                    if (col_last) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_cursor <= (next_cur > (WIDTH_W + 2)'(eff_w)) ? eff_w
                                                                   : next_cur[WIDTH_W-1:0];
                    r_state  <= S_WRITE;
                end
                S_WRITE: begin
                    r_col <= col_last ? '0 : r_col + 1'b1;
                    if (col_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (can_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if ((r_state == S_DONE) && can_load) begin
                r_ov <= 1'b1;
            end else if (o_place.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x      <= too_wide ? '0 : x_start;
            r_end    <= {1'b0, x_start} + {1'b0, i_piece.piece_width};
            r_h      <= i_piece.piece_height;
            r_y      <= '0;
            r_status <= too_wide ? ST_TOO_WIDE : ST_PLACED;
        end
        if ((r_state == S_SCAN) && in_range && (head > r_y)) begin
            r_y <= head;
        end
        if (r_state == S_CALC) begin
            r_top <= top_sum[HEIGHT_W] ? HEIGHT_MAX : top_sum[HEIGHT_W-1:0];
            if (top_sum[HEIGHT_W]) begin
                r_status <= ST_HEIGHT_SAT;
            end
        end
        if ((r_state == S_DONE) && can_load) begin
            r_out_x      <= r_x[X_W-1:0];
            r_out_y      <= r_y;
            r_out_status <= r_status;
        end
    end

    assign o_place.valid   = r_ov;
    assign o_place.place_x = r_out_x;
    assign o_place.place_y = r_out_y;
    assign o_place.status  = r_out_status;

    a_idle_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_col == '0))
        else $error("column counter not at zero between pieces");

    a_too_wide_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && too_wide) |=> (r_state == S_DONE))
        else $error("too-wide piece did not skip the ring turns");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_place.valid |-> (o_place.status != ST_RSVD))
        else $error("reserved status on output word");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_shift |-> !i_piece.ready)
        else $error("piece accepted while the ring turns");

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none
module testbench;
    import skp_pkg::*;

    localparam int COLS        = MAX_COLUMNS_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE      = 2 * COLS + 60;
    localparam int PHASES      = 10;
    localparam int PER_PHASE   = 27;

    typedef struct packed {
        logic [X_W-1:0]      x;
        logic [HEIGHT_W-1:0] y;
        logic [STATUS_W-1:0] st;
    } placement_t;

    typedef struct packed {
        logic                fresh;
        logic [WIDTH_W-1:0]  w;
        logic [HEIGHT_W-1:0] h;
        logic                known;
        placement_t          want;
    } piece_row_t;

    // typed rows assume reset defaults: width 1024, gap 2
    localparam int ROWS = 20;
    piece_row_t directed_rows [ROWS] = '{
        '{1'b0, 11'd1024, 16'd1,     1'b1, '{10'd0, 16'd0,     ST_PLACED}},
        '{1'b0, 11'd1025, 16'd5,     1'b1, '{10'd0, 16'd0,     ST_TOO_WIDE}},
        '{1'b0, 11'd2047, 16'd65535, 1'b1, '{10'd0, 16'd0,     ST_TOO_WIDE}},
        '{1'b1, 11'd1,    16'd65535, 1'b1, '{10'd0, 16'd0,     ST_PLACED}},
        '{1'b0, 11'd1,    16'd1,     1'b1, '{10'd3, 16'd0,     ST_PLACED}},
        '{1'b0, 11'd5,    16'd300,   1'b0, '{10'd0, 16'd0,     ST_PLACED}},
        '{1'b1, 11'd1024, 16'd65535, 1'b1, '{10'd0, 16'd0,     ST_PLACED}},
        '{1'b0, 11'd1024, 16'd1,     1'b1, '{10'd0, 16'd65535, ST_HEIGHT_SAT}},
        '{1'b0, 11'd512,  16'd2,     1'b1, '{10'd0, 16'd65535, ST_HEIGHT_SAT}},
        '{1'b1, 11'd0,    16'd100,   1'b1, '{10'd0, 16'd0,     ST_PLACED}},
        '{1'b0, 11'd0,    16'd7,     1'b1, '{10'd2, 16'd0,     ST_PLACED}},
        '{1'b1, 11'd1000, 16'd10,    1'b1, '{10'd0, 16'd0,     ST_PLACED}},
        '{1'b0, 11'd30,   16'd5,     1'b1, '{10'd0, 16'd10,    ST_PLACED}},
        '{1'b0, 11'd22,   16'd40,    1'b0, '{10'd0, 16'd0,     ST_PLACED}},
        '{1'b1, 11'd1025, 16'd1,     1'b1, '{10'd0, 16'd0,     ST_TOO_WIDE}},
        '{1'b0, 11'd1,    16'd1,     1'b1, '{10'd0, 16'd0,     ST_PLACED}},
        '{1'b0, 11'd700,  16'h8000,  1'b0, '{10'd0, 16'd0,     ST_PLACED}},
        '{1'b0, 11'd400,  16'h7FFF,  1'b0, '{10'd0, 16'd0,     ST_PLACED}},
        '{1'b0, 11'd2,    16'd12345, 1'b0, '{10'd0, 16'd0,     ST_PLACED}},
        '{1'b0, 11'd1023, 16'd0,     1'b0, '{10'd0, 16'd0,     ST_PLACED}}
    };

    int unsigned phase_cols [8] = '{1024, 2047, 0, 1, 8, 37, 600, 1023};
    int unsigned phase_gap  [8] = '{2,    255,  0, 0, 1, 3,  255, 0};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    skp_piece_if piece_bus ();
    skp_place_if place_bus ();

    skyline_atlas_placer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_piece (piece_bus),
        .o_place (place_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // shadow of the sheet
    logic [HEIGHT_W-1:0] skyline [COLS];
    int unsigned         cursor_col;
    int unsigned         sheet_cols;
    int unsigned         gap_cols;

    placement_t pending_places [$];
    int         error_count;
    int         cycle_count;
    bit         calm;

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        error_count++;
    endtask

    function automatic placement_t place_piece(logic fresh, logic [WIDTH_W-1:0] pw,
                                               logic [HEIGHT_W-1:0] ph);
        placement_t  r;
        int unsigned lim, x, y, top, stop, nxt;
        lim = (sheet_cols > COLS) ? COLS : sheet_cols;
        if (fresh) begin
            foreach (skyline[n]) skyline[n] = '0;
            cursor_col = 0;
        end
        if (pw > lim) begin
            r.x  = '0;
            r.y  = '0;
            r.st = ST_TOO_WIDE;
            return r;
        end
        if (cursor_col >= lim || cursor_col + pw > lim) cursor_col = 0;
        x    = cursor_col;
        stop = x + pw;
        y    = 0;
        for (int unsigned n = x; n < stop && n < COLS; n++) begin
            if (skyline[n] > y) y = skyline[n];
        end
        top  = y + ph;
        r.st = ST_PLACED;
        if (top > HEIGHT_MAX) begin
            top  = HEIGHT_MAX;
            r.st = ST_HEIGHT_SAT;
        end
        for (int unsigned n = x; n < stop && n < COLS; n++) skyline[n] = top[HEIGHT_W-1:0];
        nxt = stop + gap_cols;
        if (nxt > lim) nxt = lim;
        cursor_col = nxt & 32'h7FF;
        r.x = x[X_W-1:0];
        r.y = y[HEIGHT_W-1:0];
        return r;
    endfunction

    task automatic send_piece(logic fresh, logic [WIDTH_W-1:0] pw, logic [HEIGHT_W-1:0] ph,
                              logic known, placement_t want);
        int         gap;
        placement_t calc;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            piece_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        piece_bus.valid        <= 1'b1;
        piece_bus.new_sheet    <= fresh;
        piece_bus.piece_width  <= pw;
        piece_bus.piece_height <= ph;
        @(posedge i_clk);
        while (!piece_bus.ready) @(posedge i_clk);
        calc = place_piece(fresh, pw, ph);
        if (known) calc = want;
        pending_places = {pending_places, calc};
    endtask

    task automatic random_piece();
        int unsigned         lim, hi, r;
        logic                fresh;
        logic [WIDTH_W-1:0]  pw;
        logic [HEIGHT_W-1:0] ph;
        lim   = (sheet_cols > COLS) ? COLS : sheet_cols;
        fresh = ($urandom_range(0, 11) == 0);
        r     = $urandom_range(0, 99);
        hi    = (lim / 4 < 1) ? 1 : lim / 4;
        if (r < 6)
            pw = WIDTH_W'($urandom_range(0, 2047));
        else if (r < 9)
            pw = '0;
        else if (r < 13 && lim > 0)
            pw = WIDTH_W'(lim);
        else
            pw = WIDTH_W'($urandom_range(1, hi));
        r = $urandom_range(0, 99);
        if (r < 10)
            ph = HEIGHT_W'($urandom_range(0, 65535));
        else if (r < 16)
            ph = HEIGHT_W'($urandom_range(30000, 65535));
        else
            ph = HEIGHT_W'($urandom_range(1, 2000));
        send_piece(fresh, pw, ph, 1'b0, '0);
    endtask

    task automatic reg_write(logic idx, int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_places.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side
    initial begin
        int         stall;
        placement_t got;
        placement_t want;
        place_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                place_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            place_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!place_bus.valid) @(posedge i_clk);
            got.x  = place_bus.place_x;
            got.y  = place_bus.place_y;
            got.st = place_bus.status;
            if (pending_places.size() == 0) begin
                flag_mismatch("unexpected word place_x", got.x, 0);
            end else begin
                want = pending_places.pop_front();
                if (got.x !== want.x) flag_mismatch("place_x", got.x, want.x);
                if (got.y !== want.y) flag_mismatch("place_y", got.y, want.y);
                if (got.st !== want.st) flag_mismatch("status", got.st, want.st);
            end
        end
    end

    // piece side and sequencing
    initial begin
        int unsigned cols;
        int unsigned gap;
        error_count  = 0;
        cycle_count  = 0;
        calm         = 1'b0;
        foreach (skyline[n]) skyline[n] = '0;
        cursor_col   = 0;
        sheet_cols   = SHEET_WIDTH_RST;
        gap_cols     = COLUMN_GAP_RST;

        i_rst_n                <= 1'b0;
        piece_bus.valid        <= 1'b0;
        piece_bus.new_sheet    <= 1'b0;
        piece_bus.piece_width  <= '0;
        piece_bus.piece_height <= '0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_piece(directed_rows[k].fresh, directed_rows[k].w, directed_rows[k].h,
                       directed_rows[k].known, directed_rows[k].want);

        for (int p = 0; p < PHASES; p++) begin
            piece_bus.valid <= 1'b0;
            drain();
            if (p < 8) begin
                cols = phase_cols[p];
                gap  = phase_gap[p];
            end else begin
                cols = $urandom_range(1, 1024);
                gap  = $urandom_range(0, 255);
            end
            reg_write(REG_SHEET_WIDTH, cols);
            reg_write(REG_COLUMN_GAP, gap);
            sheet_cols = cols & 32'h7FF;
            gap_cols   = gap & 32'hFF;
            calm       = (p % 3 == 1);
            repeat (PER_PHASE) random_piece();
        end
        piece_bus.valid <= 1'b0;

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
